### rtl/lats_pkg.sv
// Shared types, constants and helper functions for the toroidal life automaton.
package lats_pkg;

	// Grid storage limits and derived widths.
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_AW   = $clog2(MAX_ROWS);
	localparam int SIZE_W   = 7;
	localparam int POP_W    = 13;
	localparam int GEN_W    = 32;
	localparam int CNT_W    = 7;
	localparam int PCNT_W   = $clog2(MAX_COLS) + 1;

	localparam logic [SIZE_W-1:0] SIZE_FLOOR = 7'd10;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
	localparam logic [SIZE_W-1:0] ROWS_HI    = SIZE_W'(MAX_ROWS);
	localparam logic [SIZE_W-1:0] COLS_HI    = SIZE_W'(MAX_COLS);

	// Action codes carried by a command transaction.
	localparam logic [2:0] ACT_SET     = 3'd0;
	localparam logic [2:0] ACT_TOGGLE  = 3'd1;
	localparam logic [2:0] ACT_READ    = 3'd2;
	localparam logic [2:0] ACT_STEP    = 3'd3;
	localparam logic [2:0] ACT_CLEAR   = 3'd4;
	localparam logic [2:0] ACT_SAVE    = 3'd5;
	localparam logic [2:0] ACT_RESTORE = 3'd6;

	// Register index, taken from paddr bit 2.
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	typedef struct packed {
		logic [2:0] action;
		logic [5:0] row;
		logic [5:0] column;
		logic       cell_in;
	} cmd_t;

	typedef struct packed {
		logic             cell_out;
		logic [POP_W-1:0] population;
		logic [GEN_W-1:0] generation_out;
	} rsp_t;

	// Saturate a configured size to the supported range.
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W-1:0] hi);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v < SIZE_FLOOR) begin
			r = SIZE_FLOOR;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	// Population count of one row: eight byte counts, then their sum.
	function automatic logic [PCNT_W-1:0] popcount_row(input logic [MAX_COLS-1:0] x);
		logic [PCNT_W-1:0] total;
		logic [3:0]        part;
		total = '0;
		for (int b = 0; b < MAX_COLS / 8; b++) begin
			part = '0;
			for (int k = 0; k < 8; k++) begin
				part = part + 4'(x[b*8+k]);
			end
			total = total + PCNT_W'(part);
		end
		return total;
	endfunction

endpackage

### rtl/lats_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lats_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/life_automaton_torus_step.sv
// Top level of the toroidal B3/S23 life automaton with snapshot storage.
// Every command transaction is handled by one row sweep over the grid memory, one 64-cell row per
// cycle, and yields one response transaction with the addressed cell, the population of the
// active area and the generation count. With H the clamped grid height, step, set, toggle, read
// and clear sweep the H active rows, and save and restore sweep all 64 stored rows because they
// copy them. The sweep runs through the single read port of the row memories, and a step needs
// two extra reads, one to fetch the last row ahead of the first and one to wrap the first row
// back under the last.
// Commands are not accepted while a sweep is running; a finished response waits in its own
// register, so the next command may be accepted before it is taken. Both grids read as all dead
// after reset through per-row valid flags, so no clearing pass is needed.
module life_automaton_torus_step import lats_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Command channel
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	// Response channel
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]          state_q;
	cmd_t                cmd_q;
	logic [SIZE_W-1:0]   width_q, height_q;
	logic [SIZE_W-1:0]   w_use, h_use;
	logic [ROW_AW-1:0]   wm1, hm1;
	logic [MAX_COLS-1:0] col_mask;
	logic                in_area;
	logic                is_step;

	logic [CNT_W-1:0]    cnt_q, cnt_last;
	logic [ROW_AW-1:0]   rd_addr;

	logic                vld_s1;
	logic [CNT_W-1:0]    idx_s1;
	logic [ROW_AW-1:0]   addr_s1;

	logic [MAX_COLS-1:0] cur_rdata, sav_rdata;
	logic [MAX_ROWS-1:0] cur_valid_q, sav_valid_q;
	logic [MAX_COLS-1:0] src_row, dn_row, life_next, new_row;
	logic [MAX_COLS-1:0] prev1_q, prev2_q, row0_q;
	logic [ROW_AW-1:0]   proc_row;
	logic                proc_en;

	logic                cur_we, sav_we;

	logic                vld_s2, cnt_en_s2, hit_s2;
	logic [MAX_COLS-1:0] row_s2;

	logic [POP_W-1:0]    pop_q;
	logic [GEN_W-1:0]    gen_q;
	logic                cell_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	// Rotate a row by one column toward higher indexes, wrapping at the active width.
	function automatic logic [MAX_COLS-1:0] wrap_left(input logic [MAX_COLS-1:0] x,
			input logic [ROW_AW-1:0] last);
		return {x[MAX_COLS-2:0], x[last]};
	endfunction

	// Rotate a row by one column toward lower indexes, wrapping at the active width.
	function automatic logic [MAX_COLS-1:0] wrap_right(input logic [MAX_COLS-1:0] x,
			input logic [ROW_AW-1:0] last);
		logic [MAX_COLS-1:0] r;
		r = {1'b0, x[MAX_COLS-1:1]};
		r[last] = x[0];
		return r;
	endfunction

	// Apply the B3/S23 rule to every column of the middle row.
	function automatic logic [MAX_COLS-1:0] life_row(input logic [MAX_COLS-1:0] up,
			input logic [MAX_COLS-1:0] mid, input logic [MAX_COLS-1:0] dn,
			input logic [ROW_AW-1:0] last);
		logic [MAX_COLS-1:0] ul, ur, ml, mr, dl, dr, nxt;
		logic [3:0]          n;
		ul = wrap_left(up, last);
		ur = wrap_right(up, last);
		ml = wrap_left(mid, last);
		mr = wrap_right(mid, last);
		dl = wrap_left(dn, last);
		dr = wrap_right(dn, last);
		for (int c = 0; c < MAX_COLS; c++) begin
			n = 4'(ul[c]) + 4'(up[c]) + 4'(ur[c]) + 4'(ml[c]) + 4'(mr[c]) +
				4'(dl[c]) + 4'(dn[c]) + 4'(dr[c]);
			nxt[c] = (n == 4'd3) | (mid[c] & (n == 4'd2));
		end
		return nxt;
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_GRID_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
				REG_GRID_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Configuration read data.
	always_comb begin
		unique case (paddr[2])
			REG_GRID_WIDTH:  prdata = {25'd0, width_q};
			REG_GRID_HEIGHT: prdata = {25'd0, height_q};
			default:         prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// Active area, column mask and addressed-cell check.
	always_comb begin
		w_use = clamp_size(width_q, COLS_HI);
		h_use = clamp_size(height_q, ROWS_HI);
		wm1   = ROW_AW'(w_use - 7'd1);
		hm1   = ROW_AW'(h_use - 7'd1);
		for (int c = 0; c < MAX_COLS; c++) begin
			col_mask[c] = (SIZE_W'(c) < w_use);
		end
		in_area = ({1'b0, cmd_q.row} < h_use) && ({1'b0, cmd_q.column} < w_use);
		is_step = (cmd_q.action == ACT_STEP);
	end

	// Sweep length and read address.
	always_comb begin
		case (cmd_q.action) inside
			ACT_STEP:                cnt_last = h_use + 7'd1;
			ACT_SAVE, ACT_RESTORE:   cnt_last = CNT_W'(MAX_ROWS - 1);
			default:                 cnt_last = h_use - 7'd1;
		endcase
		if (is_step) begin
			rd_addr = (cnt_q == '0) ? hm1 : ROW_AW'(cnt_q - 7'd1);
		end else begin
			rd_addr = cnt_q[ROW_AW-1:0];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			gen_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					cnt_q   <= '0;
					state_q <= ST_RUN;
					if (is_step) begin
						gen_q <= gen_q + 32'd1;
					end else if (cmd_q.action == ACT_RESTORE) begin
						gen_q <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == cnt_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!vld_s1 && !vld_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd_ready = (state_q == ST_IDLE);

	// Command capture.
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= cmd;
		end
	end

	// Row memories for the live grid and the snapshot.
	lats_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (proc_row),
		.wdata (new_row),
		.raddr (rd_addr),
		.rdata (cur_rdata)
	);

	lats_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_sav_ram (
		.clk   (clk),
		.we    (sav_we),
		.waddr (proc_row),
		.wdata (src_row),
		.raddr (rd_addr),
		.rdata (sav_rdata)
	);

	// Read-side pipeline register, aligned with the memory read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_RUN);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= cnt_q;
		addr_s1 <= rd_addr;
	end

	// Row processing: rule evaluation, cell edits and copies.
	always_comb begin
		if (cmd_q.action == ACT_RESTORE) begin
			src_row = sav_rdata & {MAX_COLS{sav_valid_q[addr_s1]}};
		end else begin
			src_row = cur_rdata & {MAX_COLS{cur_valid_q[addr_s1]}};
		end
		dn_row    = (idx_s1 == h_use + 7'd1) ? row0_q : src_row;
		life_next = life_row(prev2_q, prev1_q, dn_row, wm1);
		proc_row  = is_step ? ROW_AW'(idx_s1 - 7'd2) : addr_s1;
		proc_en   = vld_s1 && (!is_step || (idx_s1 >= 7'd2));
		new_row   = src_row;
		cur_we    = 1'b0;
		sav_we    = 1'b0;
		case (cmd_q.action) inside
			ACT_STEP: begin
				new_row = (life_next & col_mask) | (prev1_q & ~col_mask);
				cur_we  = proc_en;
			end
			ACT_SET, ACT_TOGGLE: begin
				if (in_area && (proc_row == cmd_q.row)) begin
					new_row[cmd_q.column] = (cmd_q.action == ACT_SET) ? cmd_q.cell_in :
						~src_row[cmd_q.column];
					cur_we = vld_s1;
				end
			end
			ACT_SAVE: sav_we = vld_s1;
			ACT_RESTORE: cur_we = vld_s1;
			default: ;
		endcase
	end

	// Step window: the two rows above the arriving one, and the original first row.
	always_ff @(posedge clk) begin
		if (vld_s1 && is_step) begin
			prev2_q <= prev1_q;
			prev1_q <= dn_row;
			if (idx_s1 == 7'd1) begin
				row0_q <= src_row;
			end
		end
	end

	// Row valid flags; a row that was never written reads as all dead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= '0;
			sav_valid_q <= '0;
		end else begin
			if (state_q == ST_START && cmd_q.action == ACT_CLEAR) begin
				cur_valid_q <= '0;
			end else if (cur_we) begin
				cur_valid_q[proc_row] <= 1'b1;
			end
			if (sav_we) begin
				sav_valid_q[proc_row] <= 1'b1;
			end
		end
	end

	// Counting stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			cnt_en_s2 <= 1'b0;
			hit_s2    <= 1'b0;
		end else begin
			vld_s2    <= proc_en;
			cnt_en_s2 <= proc_en && ({1'b0, proc_row} < h_use);
			hit_s2    <= proc_en && (proc_row == cmd_q.row);
		end
	end

	always_ff @(posedge clk) begin
		row_s2 <= new_row;
	end

	// Population accumulator and addressed-cell capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_q <= '0;
		end else if (state_q == ST_START) begin
			pop_q <= '0;
		end else if (cnt_en_s2) begin
			pop_q <= pop_q + POP_W'(popcount_row(row_s2 & col_mask));
		end
	end

	always_ff @(posedge clk) begin
		if (hit_s2) begin
			cell_q <= row_s2[cmd_q.column];
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!rsp_valid_q || rsp_ready)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!rsp_valid_q || rsp_ready)) begin
			rsp_q.cell_out       <= cell_q & in_area;
			rsp_q.population     <= pop_q;
			rsp_q.generation_out <= gen_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/lats_chk.sv
// Port-level checker for the life automaton, bound to the top level.
module lats_chk import lats_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input rsp_t        rsp
);

	logic [1:0] pend_q;
	logic       cmd_acc, rsp_acc;

	assign cmd_acc = cmd_valid && cmd_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// Commands accepted minus responses taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (cmd_acc && !rsp_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (rsp_acc && !cmd_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	// A stalled response holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// A response never appears without an outstanding command.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without a command");

	// At most one command in work and one response waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many outstanding commands");

	// The grid is busy right after a command is accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> !cmd_ready)
		else $error("command accepted while a sweep starts");

	// Population cannot exceed the grid size.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.population <= 13'd4096)
		else $error("population out of range");

endmodule

bind life_automaton_torus_step lats_chk u_lats_chk (.*);

### test/life_checker.sv
// Response checker for the toroidal life automaton: grid prediction and per-field comparison.
module life_checker import lats_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_ready,
	input  cmd_t        cmd,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          pending,
	output int          mismatches
);

	// Predicted copy of the grid, the snapshot, the counter and the size registers.
	logic [MAX_COLS-1:0] board    [MAX_ROWS];
	logic [MAX_COLS-1:0] snapshot [MAX_ROWS];
	logic [GEN_W-1:0]    gen_count;
	logic [SIZE_W-1:0]   width_reg;
	logic [SIZE_W-1:0]   height_reg;
	rsp_t                due_responses [$];
	rsp_t                wanted;
	logic [31:0]         reg_value;

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Apply one command to the predicted state and return the response it must produce.
	function automatic rsp_t apply_action(input cmd_t c);
		int                  w, h, up, dn, lf, rt, nb, live;
		logic                in_area;
		logic [MAX_COLS-1:0] nxt [MAX_ROWS];
		rsp_t                r;
		w = (width_reg < SIZE_FLOOR) ? int'(SIZE_FLOOR) :
			(int'(width_reg) > MAX_COLS) ? MAX_COLS : int'(width_reg);
		h = (height_reg < SIZE_FLOOR) ? int'(SIZE_FLOOR) :
			(int'(height_reg) > MAX_ROWS) ? MAX_ROWS : int'(height_reg);
		in_area = (int'(c.row) < h) && (int'(c.column) < w);
		case (c.action)
			ACT_SET: begin
				if (in_area) board[c.row][c.column] = c.cell_in;
			end
			ACT_TOGGLE: begin
				if (in_area) board[c.row][c.column] = ~board[c.row][c.column];
			end
			ACT_STEP: begin
				// Cells outside the active area keep their value through a generation.
				nxt = board;
				for (int r0 = 0; r0 < h; r0++) begin
					up = (r0 + h - 1) % h;
					dn = (r0 + 1) % h;
					for (int c0 = 0; c0 < w; c0++) begin
						lf = (c0 + w - 1) % w;
						rt = (c0 + 1) % w;
						nb = int'(board[up][lf]) + int'(board[up][c0]) + int'(board[up][rt]) +
							int'(board[r0][lf]) + int'(board[r0][rt]) +
							int'(board[dn][lf]) + int'(board[dn][c0]) + int'(board[dn][rt]);
						nxt[r0][c0] = board[r0][c0] ? (nb == 2 || nb == 3) : (nb == 3);
					end
				end
				board = nxt;
				gen_count = gen_count + 1'b1;
			end
			ACT_CLEAR: begin
				foreach (board[i]) board[i] = '0;
			end
			ACT_SAVE: begin
				snapshot = board;
			end
			ACT_RESTORE: begin
				board = snapshot;
				gen_count = '0;
			end
			default: begin
			end
		endcase
		// Population covers only the active area.
		live = 0;
		for (int r0 = 0; r0 < h; r0++) begin
			for (int c0 = 0; c0 < w; c0++) begin
				live += int'(board[r0][c0]);
			end
		end
		r.cell_out       = in_area ? board[c.row][c.column] : 1'b0;
		r.population     = POP_W'(live);
		r.generation_out = gen_count;
		return r;
	endfunction

	// Track transactions on all three ports in edge order.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (board[i]) begin
				board[i]    = '0;
				snapshot[i] = '0;
			end
			gen_count  = '0;
			width_reg  = SIZE_RESET;
			height_reg = SIZE_RESET;
			due_responses.delete();
			pending = 0;
		end else begin
			// A response transaction is compared with the oldest prediction.
			if (rsp_valid && rsp_ready) begin
				if (due_responses.size() == 0) begin
					report_mismatch("response with no command outstanding");
				end else begin
					wanted = due_responses.pop_front();
					if (rsp.cell_out !== wanted.cell_out)
						report_mismatch($sformatf("cell_out %0b, expected %0b",
							rsp.cell_out, wanted.cell_out));
					if (rsp.population !== wanted.population)
						report_mismatch($sformatf("population %0d, expected %0d",
							rsp.population, wanted.population));
					if (rsp.generation_out !== wanted.generation_out)
						report_mismatch($sformatf("generation_out %0d, expected %0d",
							rsp.generation_out, wanted.generation_out));
				end
			end
			// An accepted command transaction yields exactly one prediction.
			if (cmd_valid && cmd_ready) begin
				due_responses.push_back(apply_action(cmd));
			end
			// Register writes update the sizes; reads must return the stored value.
			if (psel && penable && pready) begin
				reg_value = 32'((paddr[2] == REG_GRID_HEIGHT) ? height_reg : width_reg);
				if (pwrite) begin
					if (paddr[2] == REG_GRID_HEIGHT) height_reg = pwdata[SIZE_W-1:0];
					else width_reg = pwdata[SIZE_W-1:0];
				end else if (prdata !== reg_value) begin
					report_mismatch($sformatf("prdata 0x%0h at 0x%0h, expected 0x%0h",
						prdata, paddr, reg_value));
				end
			end
			pending = due_responses.size();
		end
	end

endmodule

### test/tb.sv
// Testbench top for the toroidal life automaton: clock, reset, stimulus and verdict.
module tb;
	import lats_pkg::*;

	localparam logic [2:0] ACT_UNUSED   = 3'd7;
	localparam int         STALL_LIMIT  = 2000;
	localparam int         DRAIN_CYCLES = 80;
	localparam int         PHASES       = 6;
	localparam int         PHASE_ITEMS  = 150;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_ready;
	cmd_t        cmd       = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	int send_idle_pct = 13;
	int take_idle_pct = 73;
	int outstanding;
	int mismatches;
	int stall_cycles  = 0;
	int act_w         = MAX_COLS;
	int act_h         = MAX_ROWS;

	always #1 clk = ~clk;

	life_automaton_torus_step i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	life_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.pending   (outstanding),
		.mismatches(mismatches)
	);

	// The response side stalls at random with the current percentage.
	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= take_idle_pct);
	end

	// Watchdog: too many cycles without any transaction ends the run.
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic cmd_t cell_cmd(input logic [2:0] act, input int r, input int c,
			input logic v);
		cmd_t x;
		x.action  = act;
		x.row     = 6'(r);
		x.column  = 6'(c);
		x.cell_in = v;
		return x;
	endfunction

	// Offer one command transaction, with random gaps, and hold it until accepted.
	task automatic issue(input cmd_t c);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
	endtask

	// Stop sending and wait until every predicted response has been taken.
	task automatic settle();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	// Write one size register, then read it back.
	task automatic program_size(input logic idx, input logic [SIZE_W-1:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= 32'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Change the grid size while the block is idle and track the active area.
	task automatic set_size(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
		settle();
		program_size(REG_GRID_WIDTH, w);
		program_size(REG_GRID_HEIGHT, h);
		act_w = (w < SIZE_FLOOR) ? int'(SIZE_FLOOR) : (int'(w) > MAX_COLS) ? MAX_COLS : int'(w);
		act_h = (h < SIZE_FLOOR) ? int'(SIZE_FLOOR) : (int'(h) > MAX_ROWS) ? MAX_ROWS : int'(h);
	endtask

	initial begin
		logic [SIZE_W-1:0] width_plan  [PHASES];
		logic [SIZE_W-1:0] height_plan [PHASES];
		cmd_t              c;
		int                n, pick, r0, c0;
		width_plan  = '{7'd64, 7'd10, 7'd0, 7'd127, 7'd65, 7'd37};
		height_plan = '{7'd64, 7'd127, 7'd10, 7'd9, 7'd64, 7'd51};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: corners that meet across both wraps, snapshot handling, unused code.
		issue(cell_cmd(ACT_READ, 0, 0, 1'b1));
		issue(cell_cmd(ACT_SET, 0, 0, 1'b1));
		issue(cell_cmd(ACT_SET, 63, 63, 1'b1));
		issue(cell_cmd(ACT_TOGGLE, 0, 63, 1'b0));
		issue(cell_cmd(ACT_SET, 1, 1, 1'b0));
		issue(cell_cmd(ACT_STEP, 63, 0, 1'b0));
		issue(cell_cmd(ACT_SAVE, 63, 0, 1'b1));
		issue(cell_cmd(ACT_CLEAR, 0, 0, 1'b0));
		issue(cell_cmd(ACT_READ, 63, 0, 1'b0));
		issue(cell_cmd(ACT_RESTORE, 63, 63, 1'b0));
		issue(cell_cmd(ACT_UNUSED, 63, 0, 1'b1));
		issue(cell_cmd(ACT_STEP, 0, 0, 1'b0));

		// Directed: small grid, addresses outside the active area, blinker across the row wrap.
		set_size(7'd10, 7'd12);
		issue(cell_cmd(ACT_SET, 20, 5, 1'b1));
		issue(cell_cmd(ACT_TOGGLE, 5, 40, 1'b1));
		issue(cell_cmd(ACT_SET, 11, 9, 1'b1));
		issue(cell_cmd(ACT_SET, 0, 9, 1'b1));
		issue(cell_cmd(ACT_SET, 1, 9, 1'b1));
		issue(cell_cmd(ACT_STEP, 0, 0, 1'b0));
		issue(cell_cmd(ACT_READ, 0, 0, 1'b0));
		issue(cell_cmd(ACT_STEP, 0, 9, 1'b0));
		issue(cell_cmd(ACT_READ, 11, 9, 1'b0));

		// Directed: saturated sizes; stored rows beyond the active area survive a step.
		set_size(7'd127, 7'd0);
		issue(cell_cmd(ACT_STEP, 63, 63, 1'b1));
		issue(cell_cmd(ACT_READ, 63, 63, 1'b1));

		// Random phases: each with its own size setting; the idle pattern changes every two phases.
		for (int p = 0; p < PHASES; p++) begin
			send_idle_pct = (p < 2) ? 13 : (p < 4) ? 73 : 0;
			take_idle_pct = (p < 2) ? 73 : (p < 4) ? 13 : 0;
			set_size(width_plan[p], height_plan[p]);
			n = 0;
			while (n < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 2) begin
					settle();
				end else if (pick < 7) begin
					// Drop a glider anywhere on the torus and let it travel.
					r0 = $urandom_range(act_h - 1);
					c0 = $urandom_range(act_w - 1);
					issue(cell_cmd(ACT_SET, r0, (c0 + 1) % act_w, 1'b1));
					issue(cell_cmd(ACT_SET, (r0 + 1) % act_h, (c0 + 2) % act_w, 1'b1));
					issue(cell_cmd(ACT_SET, (r0 + 2) % act_h, c0, 1'b1));
					issue(cell_cmd(ACT_SET, (r0 + 2) % act_h, (c0 + 1) % act_w, 1'b1));
					issue(cell_cmd(ACT_SET, (r0 + 2) % act_h, (c0 + 2) % act_w, 1'b1));
					repeat (3) issue(cell_cmd(ACT_STEP, r0, c0, 1'($urandom_range(1))));
					n += 8;
				end else begin
					c.row     = 6'($urandom_range(act_h - 1));
					c.column  = 6'($urandom_range(act_w - 1));
					if ($urandom_range(9) == 0) begin
						c.row    = 6'($urandom_range(63));
						c.column = 6'($urandom_range(63));
					end
					c.cell_in = ($urandom_range(9) < 7);
					pick = $urandom_range(99);
					c.action = (pick < 30) ? ACT_SET : (pick < 45) ? ACT_TOGGLE :
						(pick < 60) ? ACT_READ : (pick < 80) ? ACT_STEP :
						(pick < 85) ? ACT_SAVE : (pick < 90) ? ACT_RESTORE :
						(pick < 95) ? ACT_CLEAR : ACT_UNUSED;
					issue(c);
					n++;
				end
			end
		end

		// Let every response arrive, then allow one more sweep before the verdict.
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
